/* rtl/core/two_way_clock_offset_tracker_defines.svh */
// Assertion macros shared by the clock offset tracker RTL.
`ifndef TWO_WAY_CLOCK_OFFSET_TRACKER_DEFINES_SVH
`define TWO_WAY_CLOCK_OFFSET_TRACKER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TWCOT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TWCOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/twcot_pkg.sv */
// Types and constants shared by the clock offset tracker files.
package twcot_pkg;

  // Width of the failure counter and of the fail limit register.
  localparam int FAIL_W = 4;

  // Fail limit value after reset.
  localparam logic [FAIL_W-1:0] FAIL_LIMIT_RST = 4'd3;

  // Action codes carried by an input item.
  typedef enum logic [1:0] {
    ACT_SEND  = 2'd0,
    ACT_RESP  = 2'd1,
    ACT_BAD   = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

endpackage

/* rtl/core/twcot_ifs.sv */
// Valid/ready channel interfaces of the clock offset tracker.
interface twcot_in_if
  import twcot_pkg::*;
#(
  parameter int TIME_BITS = 40
);
  logic                 valid;
  logic                 ready;
  action_t              action;
  logic [TIME_BITS-1:0] now_sec;
  logic [TIME_BITS-1:0] dev_sec;

  modport source (output valid, action, now_sec, dev_sec, input ready);
  modport sink (input valid, action, now_sec, dev_sec, output ready);
endinterface

interface twcot_out_if
  import twcot_pkg::*;
#(
  parameter int TIME_BITS = 40
);
  logic                      valid;
  logic                      ready;
  logic [TIME_BITS-1:0]      sent_time;
  logic signed [TIME_BITS+1:0] est_dev_time;
  logic                      sync_flag;
  logic signed [TIME_BITS:0] round_trip;
  logic signed [TIME_BITS+1:0] offset_now;
  logic                      rollback_seen;
  logic [FAIL_W-1:0]         failures;

  modport source (output valid, sent_time, est_dev_time, sync_flag, round_trip,
                  offset_now, rollback_seen, failures, input ready);
  modport sink (input valid, sent_time, est_dev_time, sync_flag, round_trip,
                offset_now, rollback_seen, failures, output ready);
endinterface

interface twcot_cfg_if
  import twcot_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FAIL_W-1:0] fail_limit;

  modport source (output valid, fail_limit, input ready);
  modport sink (input valid, fail_limit, output ready);
endinterface

/* rtl/core/two_way_clock_offset_tracker.sv */
// Top level of the two-way clock offset tracker (client side of NTP-style sync).
//
//   Channel  | Direction | Carries
//   ---------+-----------+----------------------------------------------------
//   in_ch    | in        | action, now_sec, dev_sec
//   out_ch   | out       | sent_time, est_dev_time, sync_flag, round_trip,
//            |           | offset_now, rollback_seen, failures
//   cfg_ch   | in        | fail_limit (the only register, always ready)
//
// An item first sits in the input register; the update logic then loads the
// result register from it and from the state registers. A new item is accepted
// every cycle while the result slot drains; the state update is a short chain
// of subtracts, adds and a shift from the input register and the state
// registers.
// When the result register is full and stalled, the input register still takes
// one more item; in_ch.ready then drops until out_ch.ready frees the result slot.
// Reset (rst_n low at a clock edge) empties both stages, clears all tracking
// state and sets fail_limit back to three.
`include "two_way_clock_offset_tracker_defines.svh"

module two_way_clock_offset_tracker
  import twcot_pkg::*;
#(
  parameter int TIME_BITS = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  twcot_in_if.sink     in_ch,
  twcot_out_if.source  out_ch,
  twcot_cfg_if.sink    cfg_ch
);

  localparam int RTT_W = TIME_BITS + 1;
  localparam int OFF_W = TIME_BITS + 2;

  // Input register stage.
  logic                 s1_valid_r;
  action_t              s1_action_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic [TIME_BITS-1:0] s1_dev_r;

  // Tracking state.
  logic [TIME_BITS-1:0] last_send_r, last_send_nxt;
  logic [OFF_W-1:0]     offset_r, offset_nxt;
  logic [RTT_W-1:0]     rtt_r, rtt_nxt;
  logic                 synced_r, synced_nxt;
  logic [FAIL_W-1:0]    fail_count_r, fail_count_nxt;
  logic [FAIL_W-1:0]    fail_limit_r;

  // Result register.
  logic                 out_valid_r;
  logic [TIME_BITS-1:0] out_sent_r, out_sent_nxt;
  logic [OFF_W-1:0]     out_est_r, out_est_nxt;
  logic                 out_rollback_r, out_rollback_nxt;
  logic                 out_sync_r;
  logic [RTT_W-1:0]     out_rtt_r;
  logic [OFF_W-1:0]     out_offset_r;
  logic [FAIL_W-1:0]    out_fail_r;

  logic out_adv;
  logic s1_fire;
  logic in_fire;

  // Arithmetic of the update path.
  logic [RTT_W-1:0]  rtt_meas;
  logic [RTT_W-1:0]  rtt_adj;
  logic [RTT_W-1:0]  rtt_half;
  logic [OFF_W-1:0]  mid_point;
  logic [OFF_W-1:0]  offset_meas;
  logic [OFF_W-1:0]  est_sum;
  logic [FAIL_W-1:0] fail_inc;
  logic              rollback;

  // The result slot can take a new item when empty or being drained.
  assign out_adv = !out_valid_r || out_ch.ready;
  assign s1_fire = s1_valid_r && out_adv;
  assign in_ch.ready = !s1_valid_r || out_adv;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign cfg_ch.ready = 1'b1;

  // Round trip is now minus the send time; both are unsigned, so it fits in
  // one extra bit. Halving truncates toward zero: a negative value is biased
  // by one before the arithmetic shift.
  assign rtt_meas    = {1'b0, s1_now_r} - {1'b0, last_send_r};
  assign rtt_adj     = rtt_meas + RTT_W'(rtt_meas[RTT_W-1]);
  assign rtt_half    = {rtt_adj[RTT_W-1], rtt_adj[RTT_W-1:1]};
  assign mid_point   = {2'b00, last_send_r} + {rtt_half[RTT_W-1], rtt_half};
  assign offset_meas = {2'b00, s1_dev_r} - mid_point;

  // Estimate wraps modulo the offset width, as does the offset itself.
  assign est_sum  = {2'b00, s1_now_r} + offset_r;
  assign fail_inc = fail_count_r + FAIL_W'(1);
  assign rollback = (last_send_r != '0) && (s1_now_r < last_send_r);

  always_comb begin
    last_send_nxt    = last_send_r;
    offset_nxt       = offset_r;
    rtt_nxt          = rtt_r;
    synced_nxt       = synced_r;
    fail_count_nxt   = fail_count_r;
    out_sent_nxt     = '0;
    out_est_nxt      = '0;
    out_rollback_nxt = 1'b0;
    case (s1_action_r)
      ACT_SEND: begin
        // A backward client clock wipes the state before the estimate, so the
        // estimate then reports not synced.
        if (rollback) begin
          offset_nxt       = '0;
          rtt_nxt          = '0;
          synced_nxt       = 1'b0;
          fail_count_nxt   = '0;
          out_rollback_nxt = 1'b1;
        end
        out_est_nxt   = (synced_r && !rollback) ? est_sum : '1;
        out_sent_nxt  = s1_now_r;
        last_send_nxt = s1_now_r;
      end
      ACT_RESP: begin
        rtt_nxt        = rtt_meas;
        offset_nxt     = offset_meas;
        synced_nxt     = 1'b1;
        fail_count_nxt = '0;
      end
      ACT_BAD: begin
        // Compared with >= so a count above a freshly lowered limit clears.
        if (fail_inc >= fail_limit_r) begin
          synced_nxt     = 1'b0;
          fail_count_nxt = '0;
        end else begin
          fail_count_nxt = fail_inc;
        end
      end
      default: begin
        last_send_nxt  = '0;
        offset_nxt     = '0;
        rtt_nxt        = '0;
        synced_nxt     = 1'b0;
        fail_count_nxt = '0;
      end
    endcase
  end

  // Control and tracking state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      last_send_r  <= '0;
      offset_r     <= '0;
      rtt_r        <= '0;
      synced_r     <= 1'b0;
      fail_count_r <= '0;
      fail_limit_r <= FAIL_LIMIT_RST;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        last_send_r  <= last_send_nxt;
        offset_r     <= offset_nxt;
        rtt_r        <= rtt_nxt;
        synced_r     <= synced_nxt;
        fail_count_r <= fail_count_nxt;
      end
      if (cfg_ch.valid) begin
        fail_limit_r <= cfg_ch.fail_limit;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_ch.action;
      s1_now_r    <= in_ch.now_sec;
      s1_dev_r    <= in_ch.dev_sec;
    end
    if (s1_fire) begin
      out_sent_r     <= out_sent_nxt;
      out_est_r      <= out_est_nxt;
      out_rollback_r <= out_rollback_nxt;
      out_sync_r     <= synced_nxt;
      out_rtt_r      <= rtt_nxt;
      out_offset_r   <= offset_nxt;
      out_fail_r     <= fail_count_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sent_time     = out_sent_r;
  assign out_ch.est_dev_time  = out_est_r;
  assign out_ch.sync_flag     = out_sync_r;
  assign out_ch.round_trip    = out_rtt_r;
  assign out_ch.offset_now    = out_offset_r;
  assign out_ch.rollback_seen = out_rollback_r;
  assign out_ch.failures      = out_fail_r;

  // A clear action leaves no tracking state behind.
  `TWCOT_ASSERT_NEXT(a_clear_empties, s1_fire && (s1_action_r == ACT_CLEAR),
    !synced_r && (fail_count_r == '0) && (last_send_r == '0), "clear left state")
  // A valid response always establishes sync with no failures pending.
  `TWCOT_ASSERT_NEXT(a_resp_syncs, s1_fire && (s1_action_r == ACT_RESP),
    synced_r && (fail_count_r == '0), "response did not sync")
  // A result that reports a rollback never reports sync.
  `TWCOT_ASSERT_SAME(a_rollback_unsynced, out_valid_r && out_rollback_r,
    !out_sync_r && (out_offset_r == '0), "rollback result still synced")
  // The input side only stalls when both stages hold items.
  `TWCOT_ASSERT_SAME(a_stall_full, !in_ch.ready,
    s1_valid_r && out_valid_r, "input stalled with a free stage")

endmodule

/* verif/tb_two_way_clock_offset_tracker.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the two-way clock offset tracker, with a built-in predictor.
module tb_two_way_clock_offset_tracker;
  import twcot_pkg::*;

  localparam int TIME_BITS = 40;
  // Watchdog limit, set with a wide margin over the length of a correct run.
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 310;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // One result item as the tracker reports it after a step.
  typedef struct {
    logic [TIME_BITS-1:0]        sent_time;
    logic signed [TIME_BITS+1:0] est_dev_time;
    logic                        sync_flag;
    logic signed [TIME_BITS:0]   round_trip;
    logic signed [TIME_BITS+1:0] offset_now;
    logic                        rollback_seen;
    logic [FAIL_W-1:0]           failures;
  } sync_report_t;

  logic clk;
  logic rst_n;

  twcot_in_if #(.TIME_BITS(TIME_BITS)) in_ch ();
  twcot_out_if #(.TIME_BITS(TIME_BITS)) out_ch ();
  twcot_cfg_if cfg_ch ();

  two_way_clock_offset_tracker #(.TIME_BITS(TIME_BITS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Reports the tracker should still produce, oldest first.
  sync_report_t pending_reports[$];

  // The predictor's own copy of the tracking state and of the fail limit.
  logic [TIME_BITS-1:0]        trk_send_time;
  logic signed [TIME_BITS+1:0] trk_offset;
  logic signed [TIME_BITS:0]   trk_rtt;
  logic                        trk_synced;
  logic [FAIL_W-1:0]           trk_fails;
  logic [FAIL_W-1:0]           trk_fail_limit;

  int cycle_count;
  int mismatches;
  int items_sent;
  int results_seen;
  int limits_written;
  int rollbacks_seen;
  int in_idle_pct;
  int out_idle_pct;
  int out_stall_left;

  // The client clock and device skew that the random exchanges follow.
  logic [TIME_BITS-1:0] client_clock;
  logic [TIME_BITS-1:0] device_skew;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drops all tracking state; the fail limit is kept.
  function automatic void clear_tracking();
    trk_send_time = '0;
    trk_offset    = '0;
    trk_rtt       = '0;
    trk_synced    = 1'b0;
    trk_fails     = '0;
  endfunction

  // Advances the predicted state by one accepted item and returns the report it causes.
  function automatic sync_report_t track_step(action_t act, logic [TIME_BITS-1:0] now,
                                              logic [TIME_BITS-1:0] dev);
    sync_report_t rep;
    longint span;
    longint mid;
    longint sum;
    rep.sent_time     = '0;
    rep.est_dev_time  = '0;
    rep.rollback_seen = 1'b0;
    case (act)
      ACT_SEND: begin
        // A send stamped earlier than the last one means the client clock went back.
        if (trk_send_time != '0 && now < trk_send_time) begin
          clear_tracking();
          rep.rollback_seen = 1'b1;
        end
        if (trk_synced) begin
          sum = longint'(now) + longint'(trk_offset);
          rep.est_dev_time = sum[TIME_BITS+1:0];
        end else begin
          rep.est_dev_time = '1;
        end
        rep.sent_time = now;
        trk_send_time = now;
      end
      ACT_RESP: begin
        // Division of a signed longint truncates toward zero, as the halving requires.
        span = longint'(now) - longint'(trk_send_time);
        mid = longint'(trk_send_time) + span / 2;
        sum = longint'(dev) - mid;
        trk_rtt    = span[TIME_BITS:0];
        trk_offset = sum[TIME_BITS+1:0];
        trk_synced = 1'b1;
        trk_fails  = '0;
      end
      ACT_BAD: begin
        trk_fails = trk_fails + 1'b1;
        if (trk_fails >= trk_fail_limit) begin
          trk_synced = 1'b0;
          trk_fails  = '0;
        end
      end
      default: begin
        clear_tracking();
      end
    endcase
    rep.sync_flag  = trk_synced;
    rep.round_trip = trk_rtt;
    rep.offset_now = trk_offset;
    rep.failures   = trk_fails;
    return rep;
  endfunction

  function automatic logic [TIME_BITS-1:0] random_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what);
    mismatches++;
    $display("ERROR cycle %0d result %0d: %s", cycle_count, results_seen, what);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  // Sends one item at the falling edge, possibly after a short idle burst, and
  // records its expected report once the tracker accepts it.
  task automatic send_item(action_t act, logic [TIME_BITS-1:0] now,
                           logic [TIME_BITS-1:0] dev);
    sync_report_t rep;
    @(negedge clk);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.action  = act;
    in_ch.now_sec = now;
    in_ch.dev_sec = dev;
    do @(posedge clk); while (!in_ch.ready);
    rep = track_step(act, now, dev);
    if (rep.rollback_seen) rollbacks_seen++;
    pending_reports.push_back(rep);
    items_sent++;
  endtask

  // Stops sending and waits until every report is in and the pipeline is empty.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the fail limit while the tracker is idle.
  task automatic write_fail_limit(logic [FAIL_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_ch.valid      = 1'b1;
    cfg_ch.fail_limit = value;
    do @(posedge clk); while (!cfg_ch.ready);
    trk_fail_limit = value;
    limits_written++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Extremes of the times, a response that comes before any send, negative and
  // odd round trips, and estimates formed from the largest offsets.
  task automatic test_directed_exchange();
    send_item(ACT_RESP, 40'd100, 40'd5000);
    send_item(ACT_SEND, '0, random_time());
    send_item(ACT_RESP, '0, '0);
    send_item(ACT_SEND, TIME_MAX, random_time());
    send_item(ACT_RESP, TIME_MAX, TIME_MAX);
    send_item(ACT_SEND, 40'd11, '0);
    send_item(ACT_RESP, '0, TIME_MAX);
    send_item(ACT_SEND, TIME_MAX, TIME_MAX);
    send_item(ACT_RESP, '0, '0);
    send_item(ACT_SEND, TIME_MAX, '0);
  endtask

  // Rollback detection: equal times pass, an earlier time clears, and a stored
  // send time of zero never counts as later than now.
  task automatic test_rollback_cases();
    send_item(ACT_SEND, 40'd5, '0);
    send_item(ACT_SEND, 40'd5, '0);
    send_item(ACT_SEND, 40'd4, TIME_MAX);
    send_item(ACT_CLEAR, TIME_MAX, TIME_MAX);
    send_item(ACT_SEND, '0, '0);
    send_item(ACT_SEND, '0, '0);
    send_item(ACT_SEND, 40'd1, '0);
    send_item(ACT_SEND, '0, '0);
  endtask

  // Malformed responses against the reset limit, a limit lowered below the
  // running count, and a limit of zero.
  task automatic test_fail_limit();
    send_item(ACT_RESP, 40'd7, 40'd9);
    repeat (3) send_item(ACT_BAD, random_time(), random_time());
    write_fail_limit(4'd15);
    send_item(ACT_RESP, 40'd8, 40'd9);
    repeat (5) send_item(ACT_BAD, random_time(), random_time());
    write_fail_limit(4'd2);
    send_item(ACT_BAD, '0, '0);
    write_fail_limit(4'd0);
    send_item(ACT_RESP, 40'd3, 40'd2);
    send_item(ACT_BAD, TIME_MAX, TIME_MAX);
  endtask

  // One random burst: mostly well-formed send/response exchanges on a moving
  // client clock, with malformed runs, clears, rollbacks and pure noise mixed in.
  task automatic random_burst();
    int pick;
    int n;
    logic [TIME_BITS-1:0] stamp;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      client_clock = client_clock + $urandom_range(0, 60);
      stamp = client_clock;
      send_item(ACT_SEND, stamp, random_time());
      if ($urandom_range(0, 9) == 0) send_item(ACT_BAD, random_time(), random_time());
      if ($urandom_range(0, 9) == 0) client_clock = client_clock + $urandom;
      else client_clock = client_clock + $urandom_range(0, 30);
      if ($urandom_range(0, 6) != 0) begin
        send_item(ACT_RESP, client_clock,
                  client_clock + device_skew + $urandom_range(0, 15));
      end
    end else if (pick < 70) begin
      n = $urandom_range(1, 16);
      repeat (n) send_item(ACT_BAD, random_time(), random_time());
    end else if (pick < 75) begin
      send_item(ACT_CLEAR, random_time(), random_time());
    end else if (pick < 85) begin
      client_clock = client_clock - $urandom_range(1, 1000);
      send_item(ACT_SEND, client_clock, random_time());
    end else if (pick < 95) begin
      send_item(action_t'($urandom_range(0, 3)), random_time(), random_time());
    end else begin
      client_clock = random_time();
      device_skew  = random_time();
      send_item(ACT_SEND, client_clock, random_time());
    end
  endtask

  // Random traffic across fail limit settings, extremes included; the last
  // phase runs without idling on either side.
  task automatic test_random_traffic();
    logic [FAIL_W-1:0] limits [5];
    int target;
    limits[0] = 4'd15;
    limits[1] = 4'd1;
    limits[2] = 4'd0;
    limits[3] = FAIL_W'($urandom_range(2, 14));
    limits[4] = FAIL_LIMIT_RST;
    for (int p = 0; p < 5; p++) begin
      write_fail_limit(limits[p]);
      client_clock = random_time() >> $urandom_range(0, TIME_BITS - 1);
      device_skew  = random_time();
      in_idle_pct  = (p == 4) ? 0 : $urandom_range(10, 35);
      out_idle_pct = (p == 4) ? 0 : $urandom_range(10, 35);
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) random_burst();
    end
  endtask

  // The result side stalls at random, in bursts whose length out_stall_left sets.
  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_ch.ready = 1'b0;
      out_stall_left--;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      out_ch.ready = 1'b0;
      out_stall_left = $urandom_range(0, 2);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin : check_results
    sync_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result arrived with no item waiting for it");
      end else begin
        want = pending_reports.pop_front();
        check_field("sent_time", out_ch.sent_time, want.sent_time);
        check_field("est_dev_time", out_ch.est_dev_time, want.est_dev_time);
        check_field("sync_flag", out_ch.sync_flag, want.sync_flag);
        check_field("round_trip", out_ch.round_trip, want.round_trip);
        check_field("offset_now", out_ch.offset_now, want.offset_now);
        check_field("rollback_seen", out_ch.rollback_seen, want.rollback_seen);
        check_field("failures", out_ch.failures, want.failures);
      end
      results_seen++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_reports.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_SEND;
    in_ch.now_sec     = '0;
    in_ch.dev_sec     = '0;
    out_ch.ready      = 1'b1;
    cfg_ch.valid      = 1'b0;
    cfg_ch.fail_limit = '0;
    in_idle_pct       = 25;
    out_idle_pct      = 25;
    out_stall_left    = 0;
    cycle_count       = 0;
    mismatches        = 0;
    items_sent        = 0;
    results_seen      = 0;
    limits_written    = 0;
    rollbacks_seen    = 0;
    client_clock      = '0;
    device_skew       = '0;
    clear_tracking();
    trk_fail_limit = FAIL_LIMIT_RST;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_exchange();
    test_rollback_cases();
    test_fail_limit();
    test_random_traffic();

    wait_idle();
    repeat (10) @(posedge clk);

    $display("covered %0d items and %0d results, %0d clock rollbacks,",
             items_sent, results_seen, rollbacks_seen);
    $display("under %0d fail limit writes including 0, 1 and 15", limits_written);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
